>>> src/rprop_pkg.sv
// ----------------------------------------------------------------------------
// rprop_pkg
// Shared types, constants and helpers of the resilient step-size table.
// ----------------------------------------------------------------------------
package rprop_pkg;

  // table depth, kept a power of two so the weight index folds by truncation
  localparam int unsigned NUM_WEIGHTS = 1024;
  localparam int unsigned IDX_W       = $clog2(NUM_WEIGHTS);
  localparam int unsigned CNT_W       = $clog2(NUM_WEIGHTS + 1);

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MAG_W     = 31;
  localparam int unsigned FAC_W     = 16;
  localparam int unsigned FRAC_W    = 12;
  localparam int unsigned PROD_W    = DATA_W + FAC_W;
  localparam int unsigned SCL_W     = PROD_W - FRAC_W;
  localparam int unsigned WIDX_W    = 10;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DATA_W-1:0] RATE_START_RST = 32'd1677722;
  localparam logic [FAC_W-1:0]  GROW_RST       = 16'd4915;
  localparam logic [FAC_W-1:0]  SHRINK_RST     = 16'd2048;
  localparam logic [MAG_W-1:0]  RATE_MIN_RST   = 31'd17;
  localparam logic [MAG_W-1:0]  RATE_MAX_RST   = 31'd838860800;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_START = 3'd0,
    REG_GROW       = 3'd1,
    REG_SHRINK     = 3'd2,
    REG_RATE_MIN   = 3'd3,
    REG_RATE_MAX   = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    MODE_UPDATE = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_e;

  // one table entry, kept as sign and magnitude
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } entry_t;

  typedef struct packed {
    logic              start_neg;
    logic [DATA_W-1:0] start_mag;
    logic [FAC_W-1:0]  grow;
    logic [FAC_W-1:0]  shrink;
    logic [MAG_W-1:0]  rate_min;
    logic [MAG_W-1:0]  rate_max;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic cnt_clear;
    logic cnt_inc;
  } sweep_ctl_t;

  function automatic logic in_range(input logic [MAG_W-1:0] mag,
                                    input logic [MAG_W-1:0] lo,
                                    input logic [MAG_W-1:0] hi);
    return (mag > lo) && (mag < hi);
  endfunction

endpackage

>>> src/rprop_cfg.sv
// ----------------------------------------------------------------------------
// rprop_cfg
// Configuration registers; the start rate is kept as sign and magnitude.
// ----------------------------------------------------------------------------
module rprop_cfg import rprop_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  output cfg_t                 cfg_o,
  output logic                 bounds_wr_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_neg <= RATE_START_RST[DATA_W-1];
      cfg_q.start_mag <= RATE_START_RST;
      cfg_q.grow      <= GROW_RST;
      cfg_q.shrink    <= SHRINK_RST;
      cfg_q.rate_min  <= RATE_MIN_RST;
      cfg_q.rate_max  <= RATE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RATE_START: begin
          cfg_q.start_neg <= cfg_wdata_i[DATA_W-1];
          // most negative value keeps its pattern as magnitude 2^31
          cfg_q.start_mag <= cfg_wdata_i[DATA_W-1] ? (~cfg_wdata_i + 1'b1) : cfg_wdata_i;
        end
        REG_GROW:     cfg_q.grow     <= cfg_wdata_i[FAC_W-1:0];
        REG_SHRINK:   cfg_q.shrink   <= cfg_wdata_i[FAC_W-1:0];
        REG_RATE_MIN: cfg_q.rate_min <= cfg_wdata_i[MAG_W-1:0];
        REG_RATE_MAX: cfg_q.rate_max <= cfg_wdata_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o       = cfg_q;
  assign bounds_wr_o = cfg_we_i && ((cfg_idx_i == REG_RATE_MIN) || (cfg_idx_i == REG_RATE_MAX));

endmodule

>>> src/rprop_mem.sv
// ----------------------------------------------------------------------------
// rprop_mem
// Step-size table: one write port, one registered read port with bypass.
// ----------------------------------------------------------------------------
module rprop_mem import rprop_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [NUM_WEIGHTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a read at the address being written returns the new entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rprop_sweep.sv
// ----------------------------------------------------------------------------
// rprop_sweep
// Table sequencer: clearing pass after reset and clear, recount after a
// bound changes.
// ----------------------------------------------------------------------------
module rprop_sweep import rprop_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_start_i,
  input  logic             bounds_wr_i,
  input  cfg_t             cfg_i,
  input  entry_t           rdata_i,
  output sweep_ctl_t       ctl_o,
  output logic [IDX_W-1:0] addr_o,
  output logic             we_o,
  output logic             re_o
);

  typedef enum logic [1:0] {
    SW_CLEAR,
    SW_IDLE,
    SW_SCAN,
    SW_SCAN_END
  } sweep_state_e;

  sweep_state_e     state_q;
  logic [IDX_W-1:0] addr_q;
  logic             chk_q;
  logic             last;

  assign last = (addr_q == IDX_W'(NUM_WEIGHTS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SW_CLEAR;
      addr_q  <= '0;
      chk_q   <= 1'b0;
    end else begin
      unique case (state_q)
        SW_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (last) begin
            state_q <= SW_IDLE;
            addr_q  <= '0;
          end
        end
        SW_IDLE: begin
          if (clear_start_i) begin
            state_q <= SW_CLEAR;
            addr_q  <= '0;
          end else if (bounds_wr_i) begin
            state_q <= SW_SCAN;
            addr_q  <= '0;
            chk_q   <= 1'b0;
          end
        end
        SW_SCAN: begin
          if (bounds_wr_i) begin
            addr_q <= '0;
            chk_q  <= 1'b0;
          end else begin
            chk_q  <= 1'b1;
            addr_q <= addr_q + 1'b1;
            if (last) begin
              state_q <= SW_SCAN_END;
              addr_q  <= '0;
            end
          end
        end
        SW_SCAN_END: begin
          chk_q <= 1'b0;
          if (bounds_wr_i) begin
            state_q <= SW_SCAN;
            addr_q  <= '0;
          end else begin
            state_q <= SW_IDLE;
          end
        end
        default: state_q <= SW_IDLE;
      endcase
    end
  end

  // read data belongs to the address of the cycle before
  assign ctl_o.busy      = (state_q != SW_IDLE);
  assign ctl_o.cnt_clear = bounds_wr_i && (state_q != SW_CLEAR);
  assign ctl_o.cnt_inc   = chk_q && !bounds_wr_i && rdata_i.valid &&
                           in_range(rdata_i.mag, cfg_i.rate_min, cfg_i.rate_max);
  assign addr_o = addr_q;
  assign we_o   = (state_q == SW_CLEAR);
  assign re_o   = (state_q == SW_SCAN);

  chk_in_scan_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (state_q == SW_SCAN) || (state_q == SW_SCAN_END))
    else $error("recount check outside a recount pass");

endmodule

>>> src/rprop_update.sv
// ----------------------------------------------------------------------------
// rprop_update
// Update pipeline: scale stage, clamp stage, result register, active count.
// ----------------------------------------------------------------------------
module rprop_update import rprop_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  sweep_ctl_t        sweep_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [WIDX_W-1:0] weight_index_i,
  input  logic [DATA_W-1:0] gradient_i,
  output logic              rd_en_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  input  entry_t            rdata_i,
  output logic              wr_en_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output entry_t            wr_data_o,
  output logic              clear_start_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] step_o,
  output logic              learning_stopped_o
);

  logic advance, accept, hazard, clear_busy;
  logic [IDX_W-1:0] in_idx;

  // scale stage
  logic             s1_valid_q, s1_clear_q, s1_gneg_q, s1_gzero_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic              prev_neg, use_grow, old_in;
  logic [DATA_W-1:0] prev_mag;
  logic [FAC_W-1:0]  fac;
  logic [PROD_W-1:0] prod;

  // clamp stage
  logic              s2_valid_q, s2_clear_q, s2_gneg_q, s2_gzero_q, s2_old_in_q;
  logic [IDX_W-1:0]  s2_idx_q;
  logic [PROD_W-1:0] s2_prod_q;
  logic [SCL_W-1:0]  scaled;
  logic [MAG_W-1:0]  hi_clamped, mag_new;
  logic              neg_new, new_in, s2_fire;
  logic [DATA_W-1:0] step_new;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, ls_q;
  logic [DATA_W-1:0] step_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_idx     = IDX_W'(weight_index_i);
  // the entry in the scale stage is written too late for a new read to see it
  assign hazard     = s1_valid_q && !s1_clear_q && (s1_idx_q == in_idx);
  assign clear_busy = (s1_valid_q && s1_clear_q) || (s2_valid_q && s2_clear_q);
  assign in_stall_o = !advance || sweep_i.busy || clear_busy || hazard;
  assign accept     = in_valid_i && !in_stall_o;
  assign rd_en_o    = accept;
  assign rd_addr_o  = in_idx;

  // scale stage: a never-touched entry starts from the start rate
  always_comb begin
    prev_neg = rdata_i.valid ? rdata_i.neg : cfg_i.start_neg;
    prev_mag = rdata_i.valid ? {1'b0, rdata_i.mag} : cfg_i.start_mag;
    // signs agree when the old step points where the negated gradient points
    use_grow = (!prev_neg) == s1_gneg_q;
    fac      = use_grow ? cfg_i.grow : cfg_i.shrink;
    prod     = PROD_W'(prev_mag) * PROD_W'(fac);
    old_in   = rdata_i.valid && in_range(rdata_i.mag, cfg_i.rate_min, cfg_i.rate_max);
  end

  // clamp stage: max first, then min, so min wins when the bounds cross
  always_comb begin
    scaled     = s2_prod_q[PROD_W-1:FRAC_W];
    hi_clamped = (scaled > SCL_W'(cfg_i.rate_max)) ? cfg_i.rate_max : scaled[MAG_W-1:0];
    if (s2_gzero_q) begin
      mag_new = '0;
    end else if (hi_clamped < cfg_i.rate_min) begin
      mag_new = cfg_i.rate_min;
    end else begin
      mag_new = hi_clamped;
    end
    neg_new  = !s2_gzero_q && !s2_gneg_q;
    step_new = neg_new ? (~{1'b0, mag_new} + 1'b1) : {1'b0, mag_new};
    new_in   = in_range(mag_new, cfg_i.rate_min, cfg_i.rate_max);
  end

  assign s2_fire         = s2_valid_q && advance;
  assign wr_en_o         = s2_fire && !s2_clear_q;
  assign wr_addr_o       = s2_idx_q;
  assign wr_data_o.valid = 1'b1;
  assign wr_data_o.neg   = neg_new;
  assign wr_data_o.mag   = mag_new;
  assign clear_start_o   = s2_fire && s2_clear_q;

  always_comb begin
    count_d = count_q;
    if (sweep_i.cnt_clear) begin
      count_d = '0;
    end else if (s2_fire) begin
      if (s2_clear_q) begin
        count_d = '0;
      end else begin
        count_d = count_q + CNT_W'(new_in) - CNT_W'(s2_old_in_q);
      end
    end else if (sweep_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (advance) begin
        s1_valid_q  <= accept;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_clear_q <= (mode_i == MODE_CLEAR);
      s1_idx_q   <= in_idx;
      s1_gneg_q  <= gradient_i[DATA_W-1];
      s1_gzero_q <= (gradient_i == '0);
    end
    if (advance) begin
      s2_clear_q  <= s1_clear_q;
      s2_idx_q    <= s1_idx_q;
      s2_gneg_q   <= s1_gneg_q;
      s2_gzero_q  <= s1_gzero_q;
      s2_prod_q   <= prod;
      s2_old_in_q <= old_in;
    end
    if (s2_fire) begin
      step_q <= s2_clear_q ? '0 : step_new;
      ls_q   <= (count_d == '0);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign step_o             = step_q;
  assign learning_stopped_o = ls_q;

  no_same_idx_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && !s1_clear_q && !s2_clear_q |-> s1_idx_q != s2_idx_q)
    else $error("back-to-back items on one entry reached the pipeline");

  count_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NUM_WEIGHTS))
    else $error("active count above table depth");

  clear_alone_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_clear_q |-> !s1_valid_q)
    else $error("item followed a clear into the pipeline");

endmodule

>>> src/rprop_step_size_update_top.sv
// ----------------------------------------------------------------------------
// rprop_step_size_update_top
// Resilient per-weight step-size table with clamping and activity count.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries mode, weight index and
// gradient; output channel (out_valid_o / out_stall_i) returns one result,
// the new signed step and the learning-stopped flag, per input item.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle; the block does not enforce it.
// An accepted item is read from the table at the edge that accepts it, scaled
// in the scale stage, then clamped and written back while it moves into the
// result register.
// Throughput: one item per cycle unless in_stall_o is high; an item on the same
// weight as the one just before it waits for the table read-modify-write.
// After reset and after each clear item the table is cleared by a pass over
// every entry, one entry a cycle, during which in_stall_o stays high.
// Writing rate_min or rate_max starts a recount pass over the table, also
// with in_stall_o high.
// While out_stall_i holds a result, the whole pipeline holds and in_stall_o
// is raised; the payload of a stalled result does not change.
// ----------------------------------------------------------------------------
module rprop_step_size_update_top import rprop_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [WIDX_W-1:0]    weight_index_i,
  input  logic [DATA_W-1:0]    gradient_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    step_o,
  output logic                 learning_stopped_o
);

  cfg_t             cfg;
  logic             bounds_wr;
  sweep_ctl_t       sweep_ctl;
  logic [IDX_W-1:0] sweep_addr;
  logic             sweep_we, sweep_re;
  logic             upd_re, upd_we, clear_start;
  logic [IDX_W-1:0] upd_raddr, upd_waddr;
  entry_t           upd_wdata;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;

  rprop_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .bounds_wr_o (bounds_wr)
  );

  // the sequencer only runs while the pipeline is empty
  assign mem_we    = upd_we || sweep_we;
  assign mem_waddr = sweep_we ? sweep_addr : upd_waddr;
  assign mem_wdata = sweep_we ? entry_t'('0) : upd_wdata;
  assign mem_re    = upd_re || sweep_re;
  assign mem_raddr = sweep_re ? sweep_addr : upd_raddr;

  rprop_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rprop_sweep u_sweep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_start_i (clear_start),
    .bounds_wr_i   (bounds_wr),
    .cfg_i         (cfg),
    .rdata_i       (mem_rdata),
    .ctl_o         (sweep_ctl),
    .addr_o        (sweep_addr),
    .we_o          (sweep_we),
    .re_o          (sweep_re)
  );

  rprop_update u_update (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .sweep_i            (sweep_ctl),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .weight_index_i     (weight_index_i),
    .gradient_i         (gradient_i),
    .rd_en_o            (upd_re),
    .rd_addr_o          (upd_raddr),
    .rdata_i            (mem_rdata),
    .wr_en_o            (upd_we),
    .wr_addr_o          (upd_waddr),
    .wr_data_o          (upd_wdata),
    .clear_start_o      (clear_start),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .step_o             (step_o),
    .learning_stopped_o (learning_stopped_o)
  );

  one_writer_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(upd_we && sweep_we))
    else $error("table written by pipeline and sequencer together");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the resilient step-size table. Items go in with
// random bursts and gaps, the result side stalls on its own pattern, and each
// returned step and learning-stopped flag is compared against a local model
// of the per-weight table kept in step with the register settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rprop_pkg::*;

  localparam int unsigned RESULT_LATENCY  = 3;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 116;
  localparam int unsigned LONG_HOLD       = 150;
  // index past the end of the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] step;
    logic              stopped;
  } step_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  // register rows carry the register index in the weight index column
  typedef struct packed {
    row_kind_e         kind;
    mode_e             mode;
    logic [WIDX_W-1:0] widx;
    logic [DATA_W-1:0] value;
    logic              typed;
    logic [DATA_W-1:0] exp_step;
    logic              exp_stop;
  } dir_row_t;

  localparam int unsigned NUM_ROWS = 30;
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    // first touch with zero gradient, then a zero step raised to the floor
    '{ROW_ITEM, MODE_UPDATE, 10'd0,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_ITEM, MODE_UPDATE, 10'd0,    32'hFFFF_FFFF, 1'b1, 32'h0000_0011, 1'b1},
    '{ROW_ITEM, MODE_UPDATE, 10'd1,    32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd2,    32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd1023, 32'h0000_0001, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd1023, 32'h0000_0001, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd1,    32'hFFFF_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_CLEAR,  10'd1023, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_ITEM, MODE_UPDATE, 10'd1,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    // widest grow factor and bounds, zero shrink, upper data bits set to check masking
    '{ROW_REG,  MODE_UPDATE, 10'(REG_RATE_START), 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_GROW),       32'hABCD_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_SHRINK),     32'h1234_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_RATE_MIN),   32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_RATE_MAX),   32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    // product overflow saturates at the ceiling, zero shrink drops to zero
    '{ROW_ITEM, MODE_UPDATE, 10'd5,    32'h0000_0001, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd5,    32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd5,    32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd6,    32'h0001_0000, 1'b0, 32'h0,         1'b0},
    // floor above ceiling: every nonzero step is the floor, flag always set
    '{ROW_REG,  MODE_UPDATE, 10'(REG_RATE_MIN),   32'h0000_03E8, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_RATE_MAX),   32'h0000_000A, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd6,    32'hFFFF_FFFF, 1'b1, 32'h0000_03E8, 1'b1},
    '{ROW_ITEM, MODE_UPDATE, 10'd7,    32'h0000_0002, 1'b1, 32'hFFFF_FC18, 1'b1},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_SPARE),      32'h1234_5678, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_GROW),       32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_RATE_START), 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_RATE_MIN),   32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_REG,  MODE_UPDATE, 10'(REG_RATE_MAX),   32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, MODE_UPDATE, 10'd8,    32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM, MODE_CLEAR,  10'd0,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_ITEM, MODE_UPDATE, 10'd0,    32'h8000_0000, 1'b0, 32'h0,         1'b0}
  };

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [DATA_W-1:0]    cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i         = 1'b0;
  logic [WIDX_W-1:0]    weight_index_i = '0;
  logic [DATA_W-1:0]    gradient_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [DATA_W-1:0]    step_o;
  logic                 learning_stopped_o;

  rprop_step_size_update_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .weight_index_i     (weight_index_i),
    .gradient_i         (gradient_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .step_o             (step_o),
    .learning_stopped_o (learning_stopped_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // local copy of the register file and the step table
  logic [DATA_W-1:0] cfg_start  = RATE_START_RST;
  logic [FAC_W-1:0]  cfg_grow   = GROW_RST;
  logic [FAC_W-1:0]  cfg_shrink = SHRINK_RST;
  logic [MAG_W-1:0]  cfg_min    = RATE_MIN_RST;
  logic [MAG_W-1:0]  cfg_max    = RATE_MAX_RST;
  logic [DATA_W-1:0] rate_mem [NUM_WEIGHTS];
  bit                touched  [NUM_WEIGHTS];

  step_result_t expected_steps [$];
  step_result_t oldest;

  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned clears_sent  = 0;
  int unsigned reg_writes   = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_phase  = 0;

  function automatic logic [DATA_W-1:0] rate_magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? ~v + 1'b1 : v;
  endfunction

  function automatic step_result_t predict_step(input mode_e m,
                                                input logic [WIDX_W-1:0] widx,
                                                input logic [DATA_W-1:0] grad);
    step_result_t      r;
    int unsigned       w;
    int unsigned       n_active;
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] nstep;
    longint unsigned   mag;
    logic              want_pos;
    logic              prev_pos;
    w = widx % NUM_WEIGHTS;
    if (m == MODE_CLEAR) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        touched[i]  = 1'b0;
        rate_mem[i] = '0;
      end
      r.step    = '0;
      r.stopped = 1'b1;
      return r;
    end
    if (!touched[w]) begin
      rate_mem[w] = cfg_start;
      touched[w]  = 1'b1;
    end
    nstep = '0;
    if (grad != '0) begin
      prev     = rate_mem[w];
      want_pos = grad[DATA_W-1];
      prev_pos = !prev[DATA_W-1];
      mag      = rate_magnitude(prev);
      // a zero step has no sign to compare, so it goes straight to the clamp
      if (prev != '0) begin
        mag = (mag * longint'((prev_pos == want_pos) ? cfg_grow : cfg_shrink)) >> FRAC_W;
      end
      if (mag > cfg_max) mag = cfg_max;
      if (mag < cfg_min) mag = cfg_min;
      nstep = mag[DATA_W-1:0];
      if (!want_pos) nstep = ~nstep + 1'b1;
    end
    rate_mem[w] = nstep;
    n_active = 0;
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      if (touched[i]) begin
        mag = rate_magnitude(rate_mem[i]);
        if (mag > cfg_min && mag < cfg_max) n_active++;
      end
    end
    r.step    = nstep;
    r.stopped = (n_active == 0);
    return r;
  endfunction

  // quiet the input side and let the table finish any clear or recount pass
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx, input logic [DATA_W-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ridx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (ridx)
      REG_RATE_START: cfg_start  = data;
      REG_GROW:       cfg_grow   = data[FAC_W-1:0];
      REG_SHRINK:     cfg_shrink = data[FAC_W-1:0];
      REG_RATE_MIN:   cfg_min    = data[MAG_W-1:0];
      REG_RATE_MAX:   cfg_max    = data[MAG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [DATA_W-1:0] start, input logic [FAC_W-1:0] grow,
                               input logic [FAC_W-1:0] shrink, input logic [DATA_W-1:0] lo,
                               input logic [DATA_W-1:0] hi);
    write_reg(REG_RATE_START, start);
    write_reg(REG_GROW, {16'($urandom), grow});
    write_reg(REG_SHRINK, {16'($urandom), shrink});
    write_reg(REG_RATE_MIN, lo);
    write_reg(REG_RATE_MAX, hi);
  endtask

  task automatic send_item(input mode_e m, input logic [WIDX_W-1:0] w,
                           input logic [DATA_W-1:0] g, input logic typed,
                           input step_result_t typed_r);
    step_result_t r;
    int unsigned  gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 4) ? 0
          : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    weight_index_i <= w;
    gradient_i     <= g;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_step(m, w, g);
    expected_steps.push_back(typed ? typed_r : r);
    items_sent++;
    if (m == MODE_CLEAR) clears_sent++;
  endtask

  // result side: compare each transfer, stall on a changing pattern
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_steps.size() == 0) begin
        $error("unexpected result: step %h, learning_stopped %b", step_o, learning_stopped_o);
        errors++;
      end else begin
        oldest = expected_steps.pop_front();
        if (step_o !== oldest.step) begin
          $error("step: expected %h, got %h", oldest.step, step_o);
          errors++;
        end
        if (learning_stopped_o !== oldest.stopped) begin
          $error("learning_stopped: expected %b, got %b", oldest.stopped, learning_stopped_o);
          errors++;
        end
      end
      // long back-pressure so the pipeline fills and stalls the input
      if (results_seen == 250 || results_seen == 700) hold_left = LONG_HOLD;
    end
    stall_phase++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= 1'($urandom_range(0, 1));
        2:       out_stall_i <= (stall_phase % 4 == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_steps.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned       pick;
    int unsigned       pool_size;
    int unsigned       bias;
    logic [WIDX_W-1:0] pool_base;
    logic [WIDX_W-1:0] w;
    logic [DATA_W-1:0] g;
    logic [DATA_W-1:0] s_start;
    logic [DATA_W-1:0] s_min;
    logic [DATA_W-1:0] s_max;
    logic [FAC_W-1:0]  s_grow;
    logic [FAC_W-1:0]  s_shrink;
    logic              trend_neg;
    mode_e             m;
    step_result_t      typed_r;

    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      touched[i]  = 1'b0;
      rate_mem[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        write_reg(DIRECTED[i].widx[CFG_IDX_W-1:0], DIRECTED[i].value);
      end else begin
        typed_r.step    = DIRECTED[i].exp_step;
        typed_r.stopped = DIRECTED[i].exp_stop;
        send_item(DIRECTED[i].mode, DIRECTED[i].widx, DIRECTED[i].value,
                  DIRECTED[i].typed, typed_r);
      end
    end

    typed_r = '0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        apply_setting(RATE_START_RST, GROW_RST, SHRINK_RST,
                      {1'b0, RATE_MIN_RST}, {1'b0, RATE_MAX_RST});
      end else if (ph == NUM_PHASES - 1) begin
        apply_setting(32'h8000_0000, 16'hFFFF, 16'h0000, 32'h0000_0000, 32'h7FFF_FFFF);
      end else begin
        case ($urandom_range(0, 4))
          0:       s_start = 32'h8000_0000;
          1:       s_start = 32'h7FFF_FFFF;
          2:       s_start = '0;
          default: begin
            s_start = $urandom >> $urandom_range(4, 12);
            if ($urandom_range(0, 1) == 1) s_start = ~s_start + 1'b1;
          end
        endcase
        s_grow   = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 8192));
        s_shrink = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(1024, 4095));
        if ($urandom_range(0, 5) == 0) begin
          // floor above ceiling
          s_min = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
          s_max = $urandom_range(0, 32'h00FF_FFFF);
        end else begin
          s_min = $urandom_range(0, 32'h0001_0000);
          s_max = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
        end
        s_min[DATA_W-1] = 1'($urandom_range(0, 1));
        s_max[DATA_W-1] = 1'($urandom_range(0, 1));
        apply_setting(s_start, s_grow, s_shrink, s_min, s_max);
      end

      case ($urandom_range(0, 3))
        0:       pool_size = 4;
        1:       pool_size = 16;
        2:       pool_size = 64;
        default: pool_size = NUM_WEIGHTS;
      endcase
      pool_base = WIDX_W'($urandom);
      bias      = ($urandom_range(0, 1) == 1) ? 90 : 50;
      trend_neg = 1'($urandom_range(0, 1));

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        m    = MODE_UPDATE;
        w    = WIDX_W'(pool_base + $urandom_range(0, pool_size - 1));
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          m = MODE_CLEAR;
          w = WIDX_W'($urandom);
          g = $urandom;
        end else if (pick < 10) begin
          g = '0;
        end else if (pick < 14) begin
          case ($urandom_range(0, 3))
            0:       g = 32'h8000_0000;
            1:       g = 32'h7FFF_FFFF;
            2:       g = 32'h0000_0001;
            default: g = 32'hFFFF_FFFF;
          endcase
        end else begin
          g = $urandom;
          if ($urandom_range(0, 99) < bias) g[DATA_W-1] = trend_neg;
          if (g == '0) g = 32'h0000_0001;
        end
        send_item(m, w, g, 1'b0, typed_r);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 8) @(posedge clk_i);
    $display("covered %0d items with %0d table clears, %0d register writes, %0d setting phases",
             items_sent, clears_sent, reg_writes, NUM_PHASES);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             results_seen, cycle_count, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
